/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the wrap unit.
// The macros expect a signal named clk, and TPW_ASSERT also rst, in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TPW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Property checked at every clock edge, reset included.
`define TPW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/tpw_pkg.sv */
// Shared constants of the triclinic periodic wrap unit.
// No dependencies; used by the divider, the multiply-accumulate stage and the top level.
`default_nettype none

package tpw_pkg;

  // Fractional coordinates are clamped to this signed width.
  localparam int SAT_W = 64;
  // Wide multiplier operands are split at this bit.
  localparam int HALF_W = 32;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;
  // Periodic mask value with all three axes periodic.
  localparam logic [2:0] ALL_PERIODIC = 3'b111;

endpackage

`default_nettype wire

/* rtl/tpw_if.sv */
// Valid/ready channel interfaces of the wrap unit: input positions and results.
// No dependencies.
`default_nettype none

interface tpw_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic                func;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] a_z;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] b_z;

  modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface tpw_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] wrapped_x;
  logic signed [W-1:0] wrapped_y;
  logic signed [W-1:0] wrapped_z;
  logic        [W-1:0] length;
  logic                error;

  modport source (output valid, wrapped_x, wrapped_y, wrapped_z, length, error,
                  input ready);
  modport sink (input valid, wrapped_x, wrapped_y, wrapped_z, length, error,
                output ready);
endinterface

`default_nettype wire

/* rtl/tpw_div.sv */
// Pipelined restoring floor divider with a signed 64-bit clamped quotient.
// Depends on tpw_pkg for the clamp width.
`default_nettype none

module tpw_div import tpw_pkg::*; #(
  parameter int NW   = 49,
  parameter int DIVW = 31,
  parameter int SW   = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [NW-1:0]    in_num,
  input  logic        [DIVW-1:0]  divisor,
  input  logic        [SW-1:0]    in_side,
  output logic                    out_valid,
  output logic signed [SAT_W-1:0] out_s,
  output logic        [SW-1:0]    out_side
);

  localparam int EW  = (NW > SAT_W) ? NW : SAT_W;
  localparam int QB  = SAT_W - 1;
  localparam int TW  = EW - QB;
  localparam int CMW = ((TW > DIVW) ? TW : DIVW) + 1;

  logic                valid [QB+1];
  logic                neg   [QB+1];
  logic                ov    [QB+1];
  logic [DIVW-1:0]     rem   [QB+1];
  logic [QB-1:0]       nq    [QB+1];
  logic [SW-1:0]       side  [QB+1];

  logic signed [EW-1:0] num_e;
  logic        [EW-1:0] mag;
  logic        [TW-1:0] top;

  // A negative numerator is divided as -n-1 and the quotient inverted, which gives floor.
  always_comb begin
    num_e = EW'(in_num);
    mag   = num_e[EW-1] ? ~num_e : num_e;
    top   = mag[EW-1:QB];
  end

  // Prepare stage: the quotient overflows 63 bits exactly when the top part reaches the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
    if (en) begin
      neg[0]  <= num_e[EW-1];
      ov[0]   <= CMW'(top) >= CMW'(divisor);
      rem[0]  <= DIVW'(top);
      nq[0]   <= mag[QB-1:0];
      side[0] <= in_side;
    end
  end

  // One quotient bit per stage; numerator bits shift out as quotient bits shift in.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DIVW:0]   trial;
    logic            ge;
    logic [DIVW-1:0] rem_next;

    always_comb begin
      trial    = {rem[k], nq[k][QB-1]};
      ge       = trial >= {1'b0, divisor};
      rem_next = ge ? DIVW'(trial - {1'b0, divisor}) : DIVW'(trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        neg[k+1]  <= neg[k];
        ov[k+1]   <= ov[k];
        rem[k+1]  <= rem_next;
        nq[k+1]   <= {nq[k][QB-2:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  // Clamp on overflow, otherwise restore the sign.
  always_comb begin
    if (ov[QB]) begin
      out_s = neg[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else begin
      out_s = neg[QB] ? ~{1'b0, nq[QB]} : {1'b0, nq[QB]};
    end
  end

  assign out_valid = valid[QB];
  assign out_side  = side[QB];

endmodule

`default_nettype wire

/* rtl/tpw_mac.sv */
// Three-stage multiply-accumulate: r = c - a0*b0 - a1*b1 - a2*b2 with 64-bit b operands.
// Depends on tpw_pkg for the operand split width.
`default_nettype none

module tpw_mac import tpw_pkg::*; #(
  parameter int AW = 32,
  parameter int CW = 49,
  parameter int RW = 98,
  parameter int SW = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    c,
  input  logic signed [AW-1:0]    a0,
  input  logic signed [AW-1:0]    a1,
  input  logic signed [AW-1:0]    a2,
  input  logic signed [SAT_W-1:0] b0,
  input  logic signed [SAT_W-1:0] b1,
  input  logic signed [SAT_W-1:0] b2,
  input  logic        [SW-1:0]    in_side,
  output logic                    out_valid,
  output logic signed [RW-1:0]    out_r,
  output logic        [SW-1:0]    out_side
);

  localparam int PLW = AW + HALF_W + 1;
  localparam int PHW = AW + SAT_W - HALF_W;
  localparam int PW  = AW + SAT_W;

  logic signed [AW-1:0]    a [3];
  logic signed [SAT_W-1:0] b [3];

  logic                  v1, v2;
  logic signed [PLW-1:0] plo [3];
  logic signed [PHW-1:0] phi [3];
  logic signed [PW-1:0]  prod [3];
  logic signed [CW-1:0]  c1, c2;
  logic [SW-1:0]         side1, side2;

  assign a[0] = a0;
  assign a[1] = a1;
  assign a[2] = a2;
  assign b[0] = b0;
  assign b[1] = b1;
  assign b[2] = b2;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Stage 1: partial products on the low and high halves of each b operand.
  for (genvar k = 0; k < 3; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        plo[k]  <= a[k] * $signed({1'b0, b[k][HALF_W-1:0]});
        phi[k]  <= a[k] * $signed(b[k][SAT_W-1:HALF_W]);
        prod[k] <= (PW'(phi[k]) <<< HALF_W) + PW'(plo[k]);
      end
    end
  end

  // Stage 2 is the partial product merge above; stage 3 subtracts the products from c.
  always_ff @(posedge clk) begin
    if (en) begin
      c1       <= c;
      side1    <= in_side;
      c2       <= c1;
      side2    <= side1;
      out_r    <= RW'(c2) - RW'(prod[0]) - RW'(prod[1]) - RW'(prod[2]);
      out_side <= side2;
    end
  end

endmodule

`default_nettype wire

/* rtl/tpw_sqrt.sv */
// Pipelined digit-by-digit integer square root, one result bit per stage.
// No dependencies.
`default_nettype none

module tpw_sqrt #(
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] in_rad,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [W-1:0]   out_root,
  output logic [SW-1:0]  out_side
);

  logic           valid [W+1];
  logic [W:0]     rem   [W+1];
  logic [W-1:0]   root  [W+1];
  logic [2*W-1:0] rad   [W+1];
  logic [SW-1:0]  side  [W+1];

  // Input stage: remainder and root start at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
    if (en) begin
      rem[0]  <= '0;
      root[0] <= '0;
      rad[0]  <= in_rad;
      side[0] <= in_side;
    end
  end

  // Each stage brings down two radicand bits and tries the next root bit.
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W+2:0] nv;
    logic [W+2:0] trial;
    logic         ge;

    always_comb begin
      nv    = {rem[k], rad[k][2*W-1:2*W-2]};
      trial = {1'b0, root[k], 2'b01};
      ge    = nv >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? (W+1)'(nv - trial) : (W+1)'(nv);
        root[k+1] <= {root[k][W-2:0], ge};
        rad[k+1]  <= rad[k] << 2;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = valid[W];
  assign out_root  = root[W];
  assign out_side  = side[W];

endmodule

`default_nettype wire

/* rtl/triclinic_periodic_wrap_unit.sv */
// Throughput: one transaction per cycle unless the output queue is full and not
// draining; three 64-stage floor dividers, five multiply-accumulate units and a
// square root are fully pipelined.
// A two-entry output queue lets the pipeline keep moving while a result waits.
// Reset clears valid bits and the queue; the box becomes the unit cube, all axes periodic.
`default_nettype none

module triclinic_periodic_wrap_unit import tpw_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  tpw_in_if.sink                 pos,
  tpw_out_if.source              res,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = W + 1;
  localparam int NZW = DW + F;
  localparam int RW  = W + SAT_W + 2;
  localparam int ZSW = 3 * DW + 1;
  localparam int YSW = ZSW + SAT_W;
  localparam int XSW = YSW + SAT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LX,
    REG_BOX_XY,
    REG_BOX_XZ,
    REG_BOX_LY,
    REG_BOX_YZ,
    REG_BOX_LZ,
    REG_PERIODIC_MASK
  } cfg_reg_t;

  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] z;
    logic [W-1:0] len;
    logic         err;
  } res_t;

  // Box registers.
  logic        [W-2:0] lx, ly, lz;
  logic signed [W-1:0] xy, xz, yz;
  logic        [2:0]   mask;
  logic        [W-2:0] diag_val;

  // Pipeline control.
  logic en;
  logic [1:0] cnt;
  res_t q0, q1, push_data;
  logic push, pop;

  // Input stage.
  logic                 s0_valid, s0_err;
  logic signed [DW-1:0] s0_dx, s0_dy, s0_dz;
  logic signed [DW-1:0] dx_in, dy_in, dz_in;

  // Divider and multiply-accumulate hand-offs.
  logic                    z_valid, my_valid, y_valid, mx_valid, x_valid;
  logic signed [SAT_W-1:0] z_s, y_s, x_s;
  logic [ZSW-1:0]          z_side;
  logic [YSW-1:0]          my_side, y_side;
  logic [XSW-1:0]          mx_side, x_side;
  logic signed [RW-1:0]    ty_num, tx_num;

  // Unpacked fields after the x divider.
  logic signed [DW-1:0]    xs_dx, xs_dy, xs_dz;
  logic                    xs_err;
  logic signed [SAT_W-1:0] xs_sz, xs_sy;
  logic signed [SAT_W-1:0] nx, ny, nz;

  // Wrap, clamp, square and sum stages.
  logic                 w_valid, w_err;
  logic signed [RW-1:0] wx_t, wy_t, wz_t;
  logic                 c_valid, c_err;
  logic signed [W-1:0]  cx, cy, cz;
  logic                 sq_valid, sq_err;
  logic signed [W-1:0]  sqx_w, sqy_w, sqz_w;
  logic signed [2*W-1:0] sqx, sqy, sqz;
  logic                 sm_valid, sm_err;
  logic signed [W-1:0]  smx, smy, smz;
  logic [2*W-1:0]       sm_sum;

  // Square root output.
  logic             r_valid;
  logic [W-1:0]     r_root;
  logic [3*W:0]     r_side;

  function automatic logic signed [W-1:0] sat_w(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      sat_w = {1'b0, {(W-1){1'b1}}};
    end else if (v < lo) begin
      sat_w = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_w = v[W-1:0];
    end
  endfunction

  // A diagonal written as zero acts as one unit in the last place.
  assign diag_val = (cfg_data[W-2:0] == '0) ? (W-1)'(1) : cfg_data[W-2:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      lx   <= (W-1)'(1) << F;
      ly   <= (W-1)'(1) << F;
      lz   <= (W-1)'(1) << F;
      xy   <= '0;
      xz   <= '0;
      yz   <= '0;
      mask <= ALL_PERIODIC;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOX_LX:        lx   <= diag_val;
        REG_BOX_XY:        xy   <= cfg_data;
        REG_BOX_XZ:        xz   <= cfg_data;
        REG_BOX_LY:        ly   <= diag_val;
        REG_BOX_YZ:        yz   <= cfg_data;
        REG_BOX_LZ:        lz   <= diag_val;
        REG_PERIODIC_MASK: mask <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless the output queue is full and not draining.
  assign en        = (cnt != 2'd2) || res.ready;
  assign pos.ready = en;

  // a - b (or a when func is low) is one bit wider than the inputs, so it is exact.
  always_comb begin
    dx_in = pos.func ? DW'(pos.a_x) - DW'(pos.b_x) : DW'(pos.a_x);
    dy_in = pos.func ? DW'(pos.a_y) - DW'(pos.b_y) : DW'(pos.a_y);
    dz_in = pos.func ? DW'(pos.a_z) - DW'(pos.b_z) : DW'(pos.a_z);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= pos.valid;
    end
    if (en) begin
      s0_dx  <= dx_in;
      s0_dy  <= dy_in;
      s0_dz  <= dz_in;
      s0_err <= mask != ALL_PERIODIC;
    end
  end

  // Fractional z.
  tpw_div #(.NW(NZW), .DIVW(W-1), .SW(ZSW)) u_div_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s0_valid),
    .in_num({s0_dz, {F{1'b0}}}),
    .divisor(lz),
    .in_side({s0_dx, s0_dy, s0_dz, s0_err}),
    .out_valid(z_valid), .out_s(z_s), .out_side(z_side)
  );

  // Numerator of fractional y.
  tpw_mac #(.AW(W), .CW(NZW), .RW(RW), .SW(YSW)) u_mac_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(z_valid),
    .c({z_side[DW+1 +: DW], {F{1'b0}}}),
    .a0(yz), .a1('0), .a2('0),
    .b0(z_s), .b1('0), .b2('0),
    .in_side({z_side, z_s}),
    .out_valid(my_valid), .out_r(ty_num), .out_side(my_side)
  );

  // Fractional y.
  tpw_div #(.NW(RW), .DIVW(W-1), .SW(YSW)) u_div_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(my_valid),
    .in_num(ty_num),
    .divisor(ly),
    .in_side(my_side),
    .out_valid(y_valid), .out_s(y_s), .out_side(y_side)
  );

  // Numerator of fractional x.
  tpw_mac #(.AW(W), .CW(NZW), .RW(RW), .SW(XSW)) u_mac_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(y_valid),
    .c({y_side[SAT_W+2*DW+1 +: DW], {F{1'b0}}}),
    .a0(xy), .a1(xz), .a2('0),
    .b0(y_s), .b1(y_side[SAT_W-1:0]), .b2('0),
    .in_side({y_side, y_s}),
    .out_valid(mx_valid), .out_r(tx_num), .out_side(mx_side)
  );

  // Fractional x.
  tpw_div #(.NW(RW), .DIVW(W-1), .SW(XSW)) u_div_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(mx_valid),
    .in_num(tx_num),
    .divisor(lx),
    .in_side(mx_side),
    .out_valid(x_valid), .out_s(x_s), .out_side(x_side)
  );

  // Integer cell indices are the floors of the fractional coordinates.
  assign {xs_dx, xs_dy, xs_dz, xs_err, xs_sz, xs_sy} = x_side;
  assign nx = x_s >>> F;
  assign ny = xs_sy >>> F;
  assign nz = xs_sz >>> F;

  // Wrapped vector: d minus box times cell index, one unit per axis.
  tpw_mac #(.AW(W), .CW(DW), .RW(RW), .SW(1)) u_wrap_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(x_valid),
    .c(xs_dx),
    .a0({1'b0, lx}), .a1(xy), .a2(xz),
    .b0(nx), .b1(ny), .b2(nz),
    .in_side(xs_err),
    .out_valid(w_valid), .out_r(wx_t), .out_side(w_err)
  );

  tpw_mac #(.AW(W), .CW(DW), .RW(RW), .SW(1)) u_wrap_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(x_valid),
    .c(xs_dy),
    .a0({1'b0, ly}), .a1(yz), .a2('0),
    .b0(ny), .b1(nz), .b2('0),
    .in_side(xs_err),
    .out_valid(), .out_r(wy_t), .out_side()
  );

  tpw_mac #(.AW(W), .CW(DW), .RW(RW), .SW(1)) u_wrap_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(x_valid),
    .c(xs_dz),
    .a0({1'b0, lz}), .a1('0), .a2('0),
    .b0(nz), .b1('0), .b2('0),
    .in_side(xs_err),
    .out_valid(), .out_r(wz_t), .out_side()
  );

  // Clamp, square and sum stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid  <= 1'b0;
      sq_valid <= 1'b0;
      sm_valid <= 1'b0;
    end else if (en) begin
      c_valid  <= w_valid;
      sq_valid <= c_valid;
      sm_valid <= sq_valid;
    end
    if (en) begin
      cx     <= sat_w(wx_t);
      cy     <= sat_w(wy_t);
      cz     <= sat_w(wz_t);
      c_err  <= w_err;
      sqx    <= cx * cx;
      sqy    <= cy * cy;
      sqz    <= cz * cz;
      sqx_w  <= cx;
      sqy_w  <= cy;
      sqz_w  <= cz;
      sq_err <= c_err;
      sm_sum <= $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
      smx    <= sqx_w;
      smy    <= sqy_w;
      smz    <= sqz_w;
      sm_err <= sq_err;
    end
  end

  // Length of the wrapped vector; three clamped squares never overflow its root.
  tpw_sqrt #(.W(W), .SW(3*W+1)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sm_valid),
    .in_rad(sm_sum),
    .in_side({smx, smy, smz, sm_err}),
    .out_valid(r_valid), .out_root(r_root), .out_side(r_side)
  );

  // A non-periodic box reports the error flag with all other fields zero.
  always_comb begin
    if (r_side[0]) begin
      push_data = '{x: '0, y: '0, z: '0, len: '0, err: 1'b1};
    end else begin
      push_data = '{x: r_side[2*W+1 +: W], y: r_side[W+1 +: W], z: r_side[1 +: W],
                    len: r_root, err: 1'b0};
    end
  end

  assign push = en && r_valid;
  assign pop  = res.valid && res.ready;

  // Two-entry output queue; q0 is the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push && pop) begin
      if (cnt == 2'd1) begin
        q0 <= push_data;
      end else begin
        q0 <= q1;
        q1 <= push_data;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        q0 <= push_data;
      end else begin
        q1 <= push_data;
      end
    end
  end

  assign res.valid     = cnt != 2'd0;
  assign res.wrapped_x = q0.x;
  assign res.wrapped_y = q0.y;
  assign res.wrapped_z = q0.z;
  assign res.length    = q0.len;
  assign res.error     = q0.err;

endmodule

`default_nettype wire

/* rtl/tpw_check.sv */
// Port-level checks of the wrap unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tpw_check #(
  parameter int W = 32
) (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         pos_valid,
  input wire logic         pos_ready,
  input wire logic         res_valid,
  input wire logic         res_ready,
  input wire logic [W-1:0] res_x,
  input wire logic [W-1:0] res_y,
  input wire logic [W-1:0] res_z,
  input wire logic [W-1:0] res_len,
  input wire logic         res_err
);

  logic [W-1:0] abs_x;
  logic         idle_in;

  // Magnitude of x as an unsigned number; the most negative value maps to half range.
  assign abs_x   = res_x[W-1] ? -res_x : res_x;
  assign idle_in = !pos_valid;

  // Reset empties the output queue.
  `TPW_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid after reset")

  // A waiting result stays valid, with x and length unchanged, until it is taken.
  `TPW_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_len), "stalled result changed")

  // The input stalls only while a result waits at the output.
  `TPW_ASSERT(a_stall_cause, !pos_ready |-> res_valid && !res_ready && (idle_in || pos_valid), "input stalled without a waiting result")

  // An error result carries zeros.
  `TPW_ASSERT(a_err_zero, res_valid && res_err |-> res_x == '0 && res_y == '0 && res_z == '0 && res_len == '0, "error result not zero")

  // The length is never below the magnitude of the x component.
  `TPW_ASSERT(a_len_bound, res_valid && !res_err |-> res_len >= abs_x, "length below x magnitude")

endmodule

bind triclinic_periodic_wrap_unit tpw_check #(.W(COORD_WIDTH)) u_check (
  .clk(clk),
  .rst(rst),
  .pos_valid(pos.valid),
  .pos_ready(pos.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_x(res.wrapped_x),
  .res_y(res.wrapped_y),
  .res_z(res.wrapped_z),
  .res_len(res.length),
  .res_err(res.error)
);

`default_nettype wire
